// ===== rtl/core/utf8_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8_pkg
// Shared types and constants for the UTF-8 to UTF-16 decoder.
// ----------------------------------------------------------------------------
package utf8_pkg;

  // Byte classification masks and patterns.
  localparam logic [7:0] ContMask    = 8'hc0;
  localparam logic [7:0] ContPattern = 8'h80;
  localparam logic [7:0] ContPayload = 8'h3f;
  localparam logic [7:0] Lead2Mask   = 8'h1f;
  localparam logic [7:0] Lead3Mask   = 8'h0f;
  localparam logic [7:0] AsciiMask   = 8'h7f;

  // Largest count in count-only mode.
  localparam logic [15:0] CountMax = 16'hffff;

  // Output queue depth and its pointer and fill-count widths.
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  // One result item.
  typedef struct packed {
    logic [15:0] code_unit;
    logic        is_end;
    logic [15:0] length;
  } unit_res_t;

  // Results caused by one accepted byte, in delivery order.
  typedef struct packed {
    logic [1:0] cnt;
    unit_res_t  first;
    unit_res_t  second;
  } push_t;

endpackage

// ===== rtl/core/utf8_byte_if.sv =====
// ----------------------------------------------------------------------------
// utf8_byte_if
// Valid/ready channel that carries one UTF-8 text byte per item.
// ----------------------------------------------------------------------------
interface utf8_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

// ===== rtl/core/utf8_unit_if.sv =====
// ----------------------------------------------------------------------------
// utf8_unit_if
// Valid/ready channel that carries one decoded UTF-16 result per item.
// ----------------------------------------------------------------------------
interface utf8_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        is_end;
  logic [15:0] length;

  modport source (output valid, output code_unit, output is_end, output length,
                  input ready);
  modport sink   (input valid, input code_unit, input is_end, input length,
                  output ready);
endinterface

// ===== rtl/core/utf8_dec_core.sv =====
// ----------------------------------------------------------------------------
// utf8_dec_core
// Per-string decode state and the results produced by each accepted byte.
// ----------------------------------------------------------------------------
module utf8_dec_core
  import utf8_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        byte_acc,
  input  logic [7:0]  text_byte,
  output push_t       push
);

  logic [15:0] capacity_r;
  logic [15:0] pending_r, pending_nxt;
  logic [15:0] started_r, started_nxt;
  logic        skip_r, skip_nxt;
  logic        drop_r, drop_nxt;

  logic        is_cont;
  logic        is_zero;
  logic [15:0] lead_unit;
  logic [15:0] cap_m1;
  unit_res_t   pend_res;
  unit_res_t   term_res;

  assign is_cont = (text_byte & ContMask) == ContPattern;
  assign is_zero = text_byte == 8'h00;
  assign cap_m1  = capacity_r - 16'd1;

  // Payload bits of a lead byte.
  always_comb begin
    if (!text_byte[7]) begin
      lead_unit = {8'h00, text_byte & AsciiMask};
    end else if (text_byte[7:5] == 3'b110) begin
      lead_unit = {8'h00, text_byte & Lead2Mask};
    end else begin
      lead_unit = {8'h00, text_byte & Lead3Mask};
    end
  end

  assign pend_res = '{code_unit: pending_r, is_end: 1'b0, length: 16'd0};
  assign term_res = '{code_unit: 16'd0, is_end: 1'b1, length: started_r};

  // Next state and results for the byte being accepted.
  always_comb begin
    pending_nxt = pending_r;
    started_nxt = started_r;
    skip_nxt    = skip_r;
    drop_nxt    = drop_r;
    push        = '{cnt: 2'd0, first: pend_res, second: term_res};
    if (byte_acc) begin
      if (is_zero) begin
        // End of string: flush the open unit if one is kept, then the terminator.
        if (capacity_r != 16'd0 && !drop_r && started_r != 16'd0) begin
          push.cnt = 2'd2;
        end else begin
          push.cnt   = 2'd1;
          push.first = term_res;
        end
        pending_nxt = 16'd0;
        started_nxt = 16'd0;
        skip_nxt    = 1'b1;
        drop_nxt    = 1'b0;
      end else if (!(skip_r && is_cont)) begin
        skip_nxt = 1'b0;
        if (capacity_r == 16'd0) begin
          // Count-only mode.
          if (!is_cont && started_r != CountMax) begin
            started_nxt = started_r + 16'd1;
          end
        end else if (!drop_r) begin
          if (is_cont) begin
            pending_nxt = {pending_r[9:0], text_byte[5:0] & ContPayload[5:0]};
          end else begin
            // Lead byte closes the open unit, then starts one if it fits.
            if (started_r != 16'd0) begin
              push.cnt = 2'd1;
            end
            if (started_r >= cap_m1) begin
              drop_nxt = 1'b1;
            end else begin
              started_nxt = started_r + 16'd1;
              pending_nxt = lead_unit;
            end
          end
        end
      end
    end
  end

  // Capacity register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= 16'd0;
    end else if (cfg_wr_en) begin
      capacity_r <= cfg_wr_data;
    end
  end

  // String state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 16'd0;
      started_r <= 16'd0;
      skip_r    <= 1'b1;
      drop_r    <= 1'b0;
    end else begin
      pending_r <= pending_nxt;
      started_r <= started_nxt;
      skip_r    <= skip_nxt;
      drop_r    <= drop_nxt;
    end
  end

  // An end byte always returns the string state to its start.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    byte_acc && is_zero |=> skip_r && !drop_r && started_r == 16'd0)
    else $error("string state not cleared after end byte");

  // While dropping, the unit count holds.
  a_drop_holds: assert property (@(posedge clk) disable iff (!rst_n)
    drop_r && !(byte_acc && is_zero) && capacity_r != 16'd0 && !cfg_wr_en
      |=> $stable(started_r))
    else $error("unit count moved while dropping");

endmodule

// ===== rtl/core/utf8_out_fifo.sv =====
// ----------------------------------------------------------------------------
// utf8_out_fifo
// Small result queue that takes up to two items a cycle and gives one while the reader is ready.
// ----------------------------------------------------------------------------
module utf8_out_fifo
  import utf8_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  push_t     push,
  output logic      has_room,
  output logic      out_valid,
  input  logic      out_ready,
  output unit_res_t out_res
);

  unit_res_t           mem_r [FifoDepth];
  logic [PtrW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]     count_r, count_nxt;
  logic                pop;
  logic [PtrW-1:0]     wr_ptr_p1;

  assign out_valid = count_r != '0;
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign has_room  = count_r <= CntW'(FifoDepth - 2);
  assign wr_ptr_p1 = wr_ptr_r + PtrW'(1);
  assign count_nxt = count_r + CntW'(push.cnt) - CntW'(pop);

  // Storage writes.
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.first;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.second;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PtrW'(push.cnt);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PtrW'(1);
      end
      count_r <= count_nxt;
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(FifoDepth))
    else $error("result queue overfilled");

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd0 |-> has_room)
    else $error("results pushed without room");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(!rst_n) && rst_n |-> count_r == '0)
    else $error("queue not empty after reset");

endmodule

// ===== rtl/core/utf8_to_utf16_decoder_unit.sv =====
// A byte's results are registered into the output queue and offered from it in order.
// Throughput: one byte per cycle while the result queue has room; an end byte
// that closes an open unit gives two results, delivered in turn from the output queue.
// Accept rate is set by the room left in the four-entry result queue.
// Reset (synchronous, rst_n low): capacity 0, string state cleared, queue empty.
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_unit
// Streams UTF-8 bytes in and gives UTF-16 units plus a length terminator.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder_unit
  import utf8_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  utf8_byte_if.sink   in_chan,
  utf8_unit_if.source out_chan
);

  logic      byte_acc;
  logic      has_room;
  push_t     push;
  unit_res_t out_res;

  // Bytes are taken whenever the queue can hold the worst-case two results.
  assign in_chan.ready = has_room;
  assign byte_acc      = in_chan.valid && has_room;

  utf8_dec_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .byte_acc    (byte_acc),
    .text_byte   (in_chan.text_byte),
    .push        (push)
  );

  utf8_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .has_room  (has_room),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_res   (out_res)
  );

  assign out_chan.code_unit = out_res.code_unit;
  assign out_chan.is_end    = out_res.is_end;
  assign out_chan.length    = out_res.length;

endmodule
